/* src/lbw_pkg.sv */
// ----------------------------------------------------------------------------
// lbw_pkg
// Shared types and constants of the byte-width LZW encoder.
// ----------------------------------------------------------------------------
package lbw_pkg;

    localparam int DICT_DEFAULT  = 65536;
    localparam int BASE_SYMBOLS  = 128;
    localparam int SYM_BITS      = 7;
    localparam int EPOCH_BITS    = 8;
    localparam int CODE_OUT_BITS = 16;
    localparam int BYTES_BITS    = 3;

    localparam logic [BYTES_BITS-1:0] WB_ONE   = 3'd1;
    localparam logic [BYTES_BITS-1:0] WB_TWO   = 3'd2;
    localparam logic [BYTES_BITS-1:0] WB_THREE = 3'd3;
    localparam logic [BYTES_BITS-1:0] WB_FOUR  = 3'd4;

    localparam logic [31:0] WB_STEP_TWO   = 32'h0000_00FF;
    localparam logic [31:0] WB_STEP_THREE = 32'h0000_FFFF;
    localparam logic [31:0] WB_STEP_FOUR  = 32'h00FF_FFFF;

    // classified input transaction
    typedef struct packed {
        logic [SYM_BITS-1:0] sym;
        logic                bad;
        logic                last;
    } t_item;

    // one result transaction
    typedef struct packed {
        logic [CODE_OUT_BITS-1:0] code;
        logic [BYTES_BITS-1:0]    code_bytes;
        logic                     bad_symbol;
        logic                     last_result;
    } t_res;

    // back end to front end control
    typedef struct packed {
        logic pop;
        logic busy;
    } t_back_ctl;

endpackage

/* src/lbw_front.sv */
// ----------------------------------------------------------------------------
// lbw_front
// Accepts input transactions, classifies the symbol and queues the item
// for the back end.
// ----------------------------------------------------------------------------
module lbw_front import lbw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  logic [7:0] i_symbol,
    input  logic      i_end_of_input,
    output logic      o_item_valid,
    output t_item     o_item,
    input  t_back_ctl i_ctl
);

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    logic [QAW-1:0] r_wr, n_wr;
    logic [QAW-1:0] r_rd, n_rd;
    logic [QAW:0]   r_cnt, n_cnt;
    t_item          r_q [QDEPTH];
    t_item          w_item;
    logic           w_push;
    logic           w_pop;

    // classify the incoming symbol
    always_comb begin
        w_item.sym  = i_symbol[SYM_BITS-1:0];
        w_item.bad  = i_symbol[7];
        w_item.last = i_end_of_input;
    end

    assign o_stall      = (r_cnt == (QAW+1)'(QDEPTH)) || i_ctl.busy;
    assign w_push       = i_valid && !o_stall;
    assign w_pop        = i_ctl.pop && (r_cnt != '0);
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_q[r_rd];

    // queue pointers
    always_comb begin
        n_wr  = w_push ? r_wr + 1'b1 : r_wr;
        n_rd  = w_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_item;
        end
    end

endmodule

/* src/lbw_back.sv */
// ----------------------------------------------------------------------------
// lbw_back
// Dictionary engine: hashed lookup with linear probing, entry insertion,
// code width tracking and the result register.
// ----------------------------------------------------------------------------
module lbw_back import lbw_pkg::*; #(
    parameter int DICT_ENTRIES = DICT_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_valid,
    input  t_item       i_item,
    output t_back_ctl   o_ctl,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_code,
    output logic [2:0]  o_code_bytes,
    output logic        o_bad_symbol,
    output logic        o_last_result
);

    localparam int CW    = $clog2(DICT_ENTRIES);
    localparam int EW    = CW + 1;
    localparam int KW    = CW + SYM_BITS;
    localparam int HB    = CW + 1;
    localparam int HSIZE = 1 << HB;
    localparam int SW    = EPOCH_BITS + KW + CW;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_LOOK  = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    function automatic logic [15:0] code16(input logic [CW-1:0] c);
        logic [CW+15:0] t;
        t = {16'b0, c};
        return t[15:0];
    endfunction

    function automatic logic [HB-1:0] hash_of(input logic [KW-1:0] k);
        logic [KW-1:0] s;
        s = k >> HB;
        return k[HB-1:0] ^ s[HB-1:0];
    endfunction

    logic [2:0]            r_state, n_state;
    logic [HB-1:0]         r_clr, n_clr;
    logic                  r_clr_pend, n_clr_pend;
    logic [EPOCH_BITS-1:0] r_epoch, n_epoch;
    logic [CW-1:0]         r_cur, n_cur;
    logic                  r_active, n_active;
    logic [EW-1:0]         r_count, n_count;
    logic [2:0]            r_wb, n_wb;
    t_item                 r_item, n_item;
    logic [KW-1:0]         r_key, n_key;
    logic [HB-1:0]         r_pos, n_pos;
    logic                  r_a_v, n_a_v;
    t_res                  r_a, n_a;
    logic                  r_b_v, n_b_v;
    t_res                  r_b, n_b;
    logic                  r_out_v, n_out_v;
    t_res                  r_out, n_out;

    logic [SW-1:0]         r_mem [HSIZE];
    logic [SW-1:0]         r_rdata;
    logic                  w_we;
    logic [HB-1:0]         w_wa;
    logic [SW-1:0]         w_wd;

    logic [EPOCH_BITS-1:0] w_rd_epoch;
    logic [KW-1:0]         w_rd_key;
    logic [CW-1:0]         w_rd_code;
    logic [CW-1:0]         w_sym_code;
    logic                  w_out_free;

    // item resolution scratch
    logic                  f_fin;
    logic [CW-1:0]         f_cur;
    logic                  f_active;
    logic [EW-1:0]         f_count;
    logic [2:0]            f_wb;
    logic                  f_a_v;
    t_res                  f_a;

    assign w_rd_epoch = r_rdata[SW-1 -: EPOCH_BITS];
    assign w_rd_key   = r_rdata[CW+KW-1:CW];
    assign w_rd_code  = r_rdata[CW-1:0];
    assign w_sym_code = {{(CW-SYM_BITS){1'b0}}, r_item.sym};
    assign w_out_free = !r_out_v || !i_stall;

    assign o_valid       = r_out_v;
    assign o_code        = r_out.code;
    assign o_code_bytes  = r_out.code_bytes;
    assign o_bad_symbol  = r_out.bad_symbol;
    assign o_last_result = r_out.last_result;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_clr_pend = r_clr_pend;
        n_epoch    = r_epoch;
        n_cur      = r_cur;
        n_active   = r_active;
        n_count    = r_count;
        n_wb       = r_wb;
        n_item     = r_item;
        n_key      = r_key;
        n_pos      = r_pos;
        n_a_v      = r_a_v;
        n_a        = r_a;
        n_b_v      = r_b_v;
        n_b        = r_b;
        n_out_v    = r_out_v && i_stall;
        n_out      = r_out;
        w_we       = 1'b0;
        w_wa       = r_pos;
        w_wd       = '0;
        o_ctl.pop  = 1'b0;
        o_ctl.busy = (r_state == S_CLEAR) || r_clr_pend;
        f_fin      = 1'b0;
        f_cur      = r_cur;
        f_active   = r_active;
        f_count    = r_count;
        f_wb       = r_wb;
        f_a_v      = 1'b0;
        f_a        = '0;

        case (r_state)
            S_CLEAR: begin
                w_we  = 1'b1;
                w_wa  = r_clr;
                w_wd  = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                    n_epoch = EPOCH_BITS'(1);
                end
            end
            S_IDLE: begin
                if (i_item_valid) begin
                    o_ctl.pop = 1'b1;
                    n_item    = i_item;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                if (!r_item.bad && r_active) begin
                    n_key   = {r_cur, r_item.sym};
                    n_pos   = hash_of({r_cur, r_item.sym});
                    n_state = S_LOOK;
                end else if (r_item.bad) begin
                    f_fin = 1'b1;
                    f_a_v = 1'b1;
                    f_a   = '{code: '0, code_bytes: r_wb, bad_symbol: 1'b1,
                              last_result: 1'b0};
                end else begin
                    f_fin    = 1'b1;
                    f_cur    = w_sym_code;
                    f_active = 1'b1;
                end
            end
            S_LOOK: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_rd_epoch == r_epoch) begin
                    if (w_rd_key == r_key) begin
                        f_fin = 1'b1;
                        f_cur = w_rd_code;
                    end else begin
                        n_pos   = r_pos + 1'b1;
                        n_state = S_LOOK;
                    end
                end else begin
                    // miss: emit the string and add the new entry while the dictionary has room
                    f_fin = 1'b1;
                    f_a_v = 1'b1;
                    f_a   = '{code: code16(r_cur), code_bytes: r_wb, bad_symbol: 1'b0,
                              last_result: 1'b0};
                    if (r_count < EW'(DICT_ENTRIES)) begin
                        w_we    = 1'b1;
                        w_wa    = r_pos;
                        w_wd    = {r_epoch, r_key, r_count[CW-1:0]};
                        f_count = r_count + 1'b1;
                        if (32'(f_count) == WB_STEP_TWO) begin
                            f_wb = WB_TWO;
                        end else if (32'(f_count) == WB_STEP_THREE) begin
                            f_wb = WB_THREE;
                        end else if (32'(f_count) == WB_STEP_FOUR) begin
                            f_wb = WB_FOUR;
                        end
                    end
                    f_cur = w_sym_code;
                end
            end
            S_OUT: begin
                if (r_a_v) begin
                    if (w_out_free) begin
                        n_out_v = 1'b1;
                        n_out   = r_a;
                        n_a_v   = 1'b0;
                    end
                end else if (r_b_v) begin
                    if (w_out_free) begin
                        n_out_v = 1'b1;
                        n_out   = r_b;
                        n_b_v   = 1'b0;
                    end
                end else if (r_clr_pend) begin
                    n_state    = S_CLEAR;
                    n_clr      = '0;
                    n_clr_pend = 1'b0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // commit the item outcome, flush and restart on end of stream
        if (f_fin) begin
            n_b_v = 1'b0;
            if (r_item.last) begin
                if (f_active) begin
                    n_b_v = 1'b1;
                    n_b   = '{code: code16(f_cur), code_bytes: f_wb, bad_symbol: 1'b0,
                              last_result: 1'b1};
                end else if (f_a_v) begin
                    f_a.last_result = 1'b1;
                end
                n_cur    = '0;
                n_active = 1'b0;
                n_count  = EW'(BASE_SYMBOLS);
                n_wb     = WB_ONE;
                n_epoch  = r_epoch + 1'b1;
                if (r_epoch == '1) begin
                    n_clr_pend = 1'b1;
                end
            end else begin
                n_cur    = f_cur;
                n_active = f_active;
                n_count  = f_count;
                n_wb     = f_wb;
            end
            n_a_v   = f_a_v;
            n_a     = f_a;
            n_state = S_OUT;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_clr_pend <= 1'b0;
            r_epoch    <= EPOCH_BITS'(1);
            r_cur      <= '0;
            r_active   <= 1'b0;
            r_count    <= EW'(BASE_SYMBOLS);
            r_wb       <= WB_ONE;
            r_a_v      <= 1'b0;
            r_b_v      <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_clr_pend <= n_clr_pend;
            r_epoch    <= n_epoch;
            r_cur      <= n_cur;
            r_active   <= n_active;
            r_count    <= n_count;
            r_wb       <= n_wb;
            r_a_v      <= n_a_v;
            r_b_v      <= n_b_v;
            r_out_v    <= n_out_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_key  <= n_key;
        r_pos  <= n_pos;
        r_a    <= n_a;
        r_b    <= n_b;
        r_out  <= n_out;
    end

    // hash slot memory: epoch, key and code per slot
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rdata <= r_mem[r_pos];
    end

endmodule

/* src/lzw_byte_width_encoder.sv */
// ----------------------------------------------------------------------------
// lzw_byte_width_encoder
// LZW encoder for 7-bit symbols with byte-width code sizing.
// ----------------------------------------------------------------------------
// Flow: a symbol that starts a string or is rejected is resolved in the decode
//   state; a string extension adds a lookup and a compare per hash probe.
//   Results follow in order; one symbol is in the engine at a time, and the
//   front end queues the next symbols meanwhile.
// Reset: synchronous, active low; a clearing pass over every hash slot
//   follows reset and every 255th end of stream, with no input taken.
module lzw_byte_width_encoder import lbw_pkg::*; #(
    parameter int DICT_ENTRIES = DICT_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_symbol,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_code,
    output logic [2:0]  o_code_bytes,
    output logic        o_bad_symbol,
    output logic        o_last_result
);

    logic      w_item_valid;
    t_item     w_item;
    t_back_ctl w_ctl;

    // front end: accept and classify
    lbw_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_symbol       (i_symbol),
        .i_end_of_input (i_end_of_input),
        .o_item_valid   (w_item_valid),
        .o_item         (w_item),
        .i_ctl          (w_ctl)
    );

    // back end: dictionary engine
    lbw_back #(
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (w_item_valid),
        .i_item        (w_item),
        .o_ctl         (w_ctl),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_code        (o_code),
        .o_code_bytes  (o_code_bytes),
        .o_bad_symbol  (o_bad_symbol),
        .o_last_result (o_last_result)
    );

endmodule

/* dv/lzw_byte_width_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lzw_byte_width_checker
// Watches both channels of the LZW encoder, predicts the codes of each
// accepted symbol and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module lzw_byte_width_checker import lbw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [7:0]  i_symbol,
    input  logic        i_end_of_input,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [15:0] i_code,
    input  logic [2:0]  i_code_bytes,
    input  logic        i_bad_symbol,
    input  logic        i_last_result,
    output int          o_fail_count,
    output int          o_pending
);

    // predicted encoder state; dictionary searched by key for the stream
    logic [15:0]             phrase_codes [int];
    logic [15:0]             cur_code;
    logic                    in_string;
    int unsigned             next_code;
    logic [BYTES_BITS-1:0]   cur_width;
    t_res                    code_queue [$];

    assign o_pending = code_queue.size();

    function automatic t_res make_res(logic [15:0] c, logic [2:0] b, logic bad,
                                      logic lst);
        t_res r;
        r.code = c;
        r.code_bytes = b;
        r.bad_symbol = bad;
        r.last_result = lst;
        return r;
    endfunction

    task automatic restart_stream();
        phrase_codes.delete();
        cur_code = '0;
        in_string = 1'b0;
        next_code = BASE_SYMBOLS;
        cur_width = WB_ONE;
    endtask

    // predict the results of one accepted symbol
    task automatic encode_symbol(logic [7:0] sym, logic eoi);
        logic [22:0] key;
        int n;
        n = 0;
        if (sym >= BASE_SYMBOLS) begin
            code_queue.push_back(make_res(16'd0, cur_width, 1'b1, 1'b0));
            n = 1;
        end else if (!in_string) begin
            cur_code = {9'd0, sym[6:0]};
            in_string = 1'b1;
        end else begin
            key = {cur_code, sym[6:0]};
            if (phrase_codes.exists(int'(key))) begin
                cur_code = phrase_codes[int'(key)];
            end else begin
                code_queue.push_back(make_res(cur_code, cur_width, 1'b0, 1'b0));
                n = 1;
                if (next_code < DICT_DEFAULT) begin
                    phrase_codes[int'(key)] = next_code[15:0];
                    next_code++;
                    if (next_code == WB_STEP_TWO) cur_width = WB_TWO;
                    else if (next_code == WB_STEP_THREE) cur_width = WB_THREE;
                    else if (next_code == WB_STEP_FOUR) cur_width = WB_FOUR;
                end
                cur_code = {9'd0, sym[6:0]};
            end
        end
        if (eoi) begin
            if (in_string)
                code_queue.push_back(make_res(cur_code, cur_width, 1'b0, 1'b1));
            else if (n > 0)
                code_queue[$].last_result = 1'b1;
            restart_stream();
        end
    endtask

    // watch both channels
    always @(posedge i_clk) begin
        t_res act, exp_r;
        if (!i_rst_n) begin
            restart_stream();
            code_queue.delete();
            o_fail_count <= 0;
        end else begin
            if (i_valid && !i_stall_in)
                encode_symbol(i_symbol, i_end_of_input);
            if (i_res_valid && !i_res_stall) begin
                act = make_res(i_code, i_code_bytes, i_bad_symbol, i_last_result);
                if (code_queue.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, got %h",
                             $realtime, act);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = code_queue.pop_front();
                    if (act !== exp_r) begin
                        $display("%0t: mismatch code exp %h got %h, bytes exp %0d got %0d",
                                 $realtime, exp_r.code, act.code, exp_r.code_bytes,
                                 act.code_bytes);
                        $display("%0t:   bad exp %b got %b, last exp %b got %b",
                                 $realtime, exp_r.bad_symbol, act.bad_symbol,
                                 exp_r.last_result, act.last_result);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* dv/tb_lzw_byte_width_encoder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lzw_byte_width_encoder
// Drives directed and random symbol streams through the LZW encoder under
// several idling patterns; the checker predicts and compares the codes.
// ----------------------------------------------------------------------------
module tb_lzw_byte_width_encoder;
    import lbw_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_symbol;
    logic        i_end_of_input;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_code;
    logic [2:0]  o_code_bytes;
    logic        o_bad_symbol;
    logic        o_last_result;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          idle_cycles;

    lzw_byte_width_encoder dut (.*);

    lzw_byte_width_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_stall_in(o_stall),
        .i_symbol(i_symbol), .i_end_of_input(i_end_of_input),
        .i_res_valid(o_valid), .i_res_stall(i_stall),
        .i_code(o_code), .i_code_bytes(o_code_bytes),
        .i_bad_symbol(o_bad_symbol), .i_last_result(o_last_result),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on cycles with no accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("lzw_byte_width_encoder regression: fail");
            $finish;
        end
    end

    // send one symbol, idling before it as the phase dictates
    task automatic send_symbol(logic [7:0] sym, logic eoi);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_symbol <= sym;
        i_end_of_input <= eoi;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // one stream closed by end of input; a small alphabet makes strings repeat
    task automatic send_stream(int len, int alpha, int bad_pct);
        logic [7:0] sym;
        for (int k = 0; k < len; k++) begin
            sym = 8'($urandom_range(alpha - 1) + $urandom_range(1) * 8'h40);
            if ($urandom_range(99) < bad_pct) sym = 8'($urandom_range(255, 128));
            send_symbol(sym, k == len - 1);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_symbol = '0;
        i_end_of_input = 1'b0;
        i_stall = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, rejected symbols, flushes, repeats
        send_symbol(8'hFF, 1'b1);
        send_symbol(8'h80, 1'b0);
        send_symbol(8'h00, 1'b1);
        send_symbol(8'h7F, 1'b0);
        send_symbol(8'h7F, 1'b0);
        send_symbol(8'h7F, 1'b0);
        send_symbol(8'h7F, 1'b0);
        send_symbol(8'hAA, 1'b0);
        send_symbol(8'h55, 1'b0);
        send_symbol(8'h2A, 1'b0);
        send_symbol(8'h55, 1'b0);
        send_symbol(8'h2A, 1'b0);
        send_symbol(8'h55, 1'b0);
        send_symbol(8'hC3, 1'b1);
        send_symbol(8'h01, 1'b1);
        // pause until all results are out
        drain();

        // long stream crossing the two-byte width step
        send_stream(300, 128, 0);
        drain();

        // random streams over the idling phases
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 24 : 60) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 24 : 60) : 0;
            for (int s = 0; s < 7; s++)
                send_stream($urandom_range(40, 1), $urandom_range(6, 1), 8);
        end

        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("lzw_byte_width_encoder regression: pass");
        else
            $display("lzw_byte_width_encoder regression: fail");
        $finish;
    end

endmodule

/* sim.f */
src/lbw_pkg.sv
src/lbw_front.sv
src/lbw_back.sv
src/lzw_byte_width_encoder.sv
dv/lzw_byte_width_checker.sv
dv/tb_lzw_byte_width_encoder.sv
